>>> hdl/plil_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolation table: shared definitions
// Field widths, stream packing offsets, result codes and sequencer states.
// ----------------------------------------------------------------------------
package plil_pkg;

	localparam int unsigned TABLE_ROWS_DEF = 64;

	localparam int unsigned ROW_IDX_W = 6;
	localparam int unsigned FORCE_W   = 16;
	localparam int unsigned PWM_W     = 16;
	localparam int unsigned CLAMP_W   = 2;

	localparam int unsigned MEM_W  = FORCE_W + PWM_W;
	localparam int unsigned PROD_W = 2 * PWM_W;
	localparam int unsigned DEN_W  = FORCE_W;

	localparam int unsigned ROW_IDX_LSB   = 0;
	localparam int unsigned ROW_FORCE_LSB = ROW_IDX_LSB + ROW_IDX_W;
	localparam int unsigned ROW_PWM_LSB   = ROW_FORCE_LSB + FORCE_W;
	localparam int unsigned QUERY_LSB     = ROW_PWM_LSB + PWM_W;
	localparam int unsigned IN_BITS       = QUERY_LSB + FORCE_W;
	localparam int unsigned IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W   = ((PWM_W + 7) / 8) * 8;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
	localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd1;
	localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK_LAST,
		ST_WAIT_FIRST,
		ST_CHK_FIRST,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_RESP
	} state_t;

endpackage

>>> hdl/plil_table_mem.sv
// ----------------------------------------------------------------------------
// Breakpoint table memory
// One write port and one read port with registered read data; each word
// holds a breakpoint force above its PWM code.
// ----------------------------------------------------------------------------
module plil_table_mem #(
	parameter int unsigned DEPTH = plil_pkg::TABLE_ROWS_DEF,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  logic [plil_pkg::MEM_W-1:0] wdata,
	input  logic [ADDR_W-1:0]          raddr,
	output logic [plil_pkg::MEM_W-1:0] rdata
);
	import plil_pkg::*;

	logic [MEM_W-1:0] mem_q [DEPTH];
	logic [MEM_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/plil_divider.sv
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle, with a pulse when done.
// ----------------------------------------------------------------------------
module plil_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [plil_pkg::PROD_W-1:0] dividend,
	input  logic [plil_pkg::DEN_W-1:0]  divisor,
	output logic                       done,
	output logic [plil_pkg::PWM_W-1:0]  quotient
);
	import plil_pkg::*;

	localparam int unsigned CNT_W = $clog2(PROD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] dvd_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              fits;

	assign trial = {rem_q, dvd_q[PROD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = !diff[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(PROD_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			dvd_q <= {dvd_q[PROD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q[PWM_W-1:0];

endmodule

>>> hdl/piecewise_linear_interp_lut.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolation lookup table
// Breakpoint table of forces and PWM codes with clamping and interpolation.
// ----------------------------------------------------------------------------
// A write transaction (tuser 0) loads one table row; rows at or beyond
// TABLE_ROWS are ignored. A query transaction (tuser 1) returns one result:
// a force above the last row's or below the first row's is answered from the
// end rows, and an interpolated answer waits on the scan of one row per cycle
// through the single read port of the table and on the bit-serial divider,
// which gives one quotient bit per cycle. The block takes no new transaction
// while a query is in progress, but a finished result may wait in the output
// register while the next transaction is accepted. Every row that a query may
// visit must have been written since reset.
// ----------------------------------------------------------------------------
module piecewise_linear_interp_lut #(
	parameter int unsigned TABLE_ROWS = plil_pkg::TABLE_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// row_index [5:0], row_force [21:6], row_pwm [37:22], query_force [53:38]
	input  logic [plil_pkg::IN_TDATA_W-1:0]  s_tdata,
	// req_type [0]
	input  logic [0:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// pwm_code [15:0]
	output logic [plil_pkg::OUT_TDATA_W-1:0] m_tdata,
	// clamped [1:0]
	output logic [plil_pkg::CLAMP_W-1:0]     m_tuser
);
	import plil_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_ROWS);
	localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(TABLE_ROWS - 1);

	state_t state_q, state_d;

	logic [IDX_W-1:0]          addr_q;
	logic [IDX_W-1:0]          cur_row_q;
	logic signed [FORCE_W-1:0] q_q;
	logic signed [FORCE_W-1:0] prev_x_q;
	logic [PWM_W-1:0]          prev_y_q;
	logic [PWM_W-1:0]          mag_q;
	logic [PWM_W-1:0]          dq_q;
	logic [DEN_W-1:0]          den_q;
	logic                      neg_q;
	logic [PWM_W-1:0]          res_pwm_q;
	logic [CLAMP_W-1:0]        res_clamp_q;
	logic                      m_tvalid_q;
	logic [PWM_W-1:0]          m_pwm_q;
	logic [CLAMP_W-1:0]        m_clamp_q;

	logic                      s_accept;
	logic                      row_ok;
	logic                      mem_we;
	logic [IDX_W-1:0]          mem_waddr;
	logic [MEM_W-1:0]          mem_wdata;
	logic [MEM_W-1:0]          rd_word;
	logic signed [FORCE_W-1:0] rd_force;
	logic [PWM_W-1:0]          rd_pwm;
	logic signed [FORCE_W-1:0] s_query;

	logic                      above_last;
	logic                      below_first;
	logic                      in_interval;
	logic                      ends_equal;
	logic                      last_row;
	logic [FORCE_W:0]          dq_full;
	logic [FORCE_W:0]          den_full;
	logic [PWM_W:0]            dy_full;
	logic [PWM_W:0]            dy_mag;

	logic                      div_start;
	logic                      div_done;
	logic [PWM_W-1:0]          div_quot;
	logic [PROD_W-1:0]         product;
	logic [PWM_W:0]            interp_full;
	logic                      out_load;

	assign s_accept  = s_tvalid && s_tready;
	assign row_ok    = 32'(s_tdata[ROW_IDX_LSB +: ROW_IDX_W]) < TABLE_ROWS;
	assign mem_we    = s_accept && (s_tuser[0] == REQ_WRITE) && row_ok;
	assign mem_waddr = IDX_W'(s_tdata[ROW_IDX_LSB +: ROW_IDX_W]);
	assign mem_wdata = {s_tdata[ROW_FORCE_LSB +: FORCE_W], s_tdata[ROW_PWM_LSB +: PWM_W]};
	assign s_query   = s_tdata[QUERY_LSB +: FORCE_W];

	plil_table_mem #(
		.DEPTH  (TABLE_ROWS),
		.ADDR_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_q),
		.rdata (rd_word)
	);

	assign rd_force = rd_word[MEM_W-1:PWM_W];
	assign rd_pwm   = rd_word[PWM_W-1:0];

	assign above_last  = q_q > rd_force;
	assign below_first = q_q < rd_force;
	assign in_interval = (q_q >= prev_x_q) && (q_q <= rd_force);
	assign ends_equal  = rd_force == prev_x_q;
	assign last_row    = cur_row_q == LAST_ROW;
	assign dq_full     = {q_q[FORCE_W-1], q_q} - {prev_x_q[FORCE_W-1], prev_x_q};
	assign den_full    = {rd_force[FORCE_W-1], rd_force} - {prev_x_q[FORCE_W-1], prev_x_q};
	assign dy_full     = {1'b0, rd_pwm} - {1'b0, prev_y_q};
	assign dy_mag      = dy_full[PWM_W] ? (~dy_full + 1'b1) : dy_full;

	assign product = mag_q * dq_q;

	plil_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign interp_full = neg_q ? ({1'b0, prev_y_q} - {1'b0, div_quot})
	                           : ({1'b0, prev_y_q} + {1'b0, div_quot});

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_accept && (s_tuser[0] == REQ_QUERY)) begin
					state_d = ST_CHK_LAST;
				end
			end
			ST_CHK_LAST: begin
				state_d = above_last ? ST_RESP : ST_WAIT_FIRST;
			end
			ST_WAIT_FIRST: begin
				state_d = ST_CHK_FIRST;
			end
			ST_CHK_FIRST: begin
				state_d = below_first ? ST_RESP : ST_SCAN;
			end
			ST_SCAN: begin
				if (in_interval) begin
					state_d = ends_equal ? ST_RESP : ST_MUL;
				end else if (last_row) begin
					state_d = ST_RESP;
				end
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready  = state_q == ST_IDLE;
		div_start = state_q == ST_MUL;
		out_load  = (state_q == ST_RESP) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			addr_q     <= LAST_ROW;
			cur_row_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CHK_LAST: begin
					addr_q <= '0;
				end
				ST_WAIT_FIRST, ST_CHK_FIRST, ST_SCAN: begin
					addr_q <= addr_q + 1'b1;
				end
				default: begin
					addr_q <= LAST_ROW;
				end
			endcase
			if (state_q == ST_CHK_FIRST) begin
				cur_row_q <= IDX_W'(1);
			end else if (state_q == ST_SCAN) begin
				cur_row_q <= cur_row_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					q_q <= s_query;
				end
			end
			ST_CHK_LAST: begin
				res_pwm_q   <= rd_pwm;
				res_clamp_q <= CLAMP_HIGH;
			end
			ST_CHK_FIRST: begin
				prev_x_q    <= rd_force;
				prev_y_q    <= rd_pwm;
				res_pwm_q   <= rd_pwm;
				res_clamp_q <= CLAMP_LOW;
			end
			ST_SCAN: begin
				res_clamp_q <= CLAMP_NONE;
				if (in_interval) begin
					res_pwm_q <= prev_y_q;
					dq_q      <= dq_full[PWM_W-1:0];
					den_q     <= den_full[DEN_W-1:0];
					mag_q     <= dy_mag[PWM_W-1:0];
					neg_q     <= dy_full[PWM_W];
				end else begin
					res_pwm_q <= '0;
					prev_x_q  <= rd_force;
					prev_y_q  <= rd_pwm;
				end
			end
			ST_DIV: begin
				res_pwm_q <= interp_full[PWM_W-1:0];
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_pwm_q   <= res_pwm_q;
			m_clamp_q <= res_clamp_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(m_pwm_q);
	assign m_tuser  = m_clamp_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the division state");

	a_busy_after_query: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && (s_tuser[0] == REQ_QUERY)) |=> !s_tready)
		else $error("ready again straight after a query transaction");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_DIV) |-> den_q != '0)
		else $error("division started with a zero interval width");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over an untaken result");

endmodule

>>> dv/plil_response_checker.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolation table: response checker
// Watches both stream channels, keeps its own copy of the breakpoint table,
// predicts the answer to every query and compares each result in order.
// ----------------------------------------------------------------------------
module plil_response_checker #(
	parameter int unsigned ROWS = plil_pkg::TABLE_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [plil_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [0:0]                       s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [plil_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic [plil_pkg::CLAMP_W-1:0]     m_tuser,
	output int unsigned                      mismatches,
	output int unsigned                      outstanding
);
	import plil_pkg::*;

	typedef struct packed {
		logic [PWM_W-1:0]   pwm;
		logic [CLAMP_W-1:0] clamp;
	} pwm_answer_t;

	logic signed [FORCE_W-1:0] bp_force [ROWS];
	logic [PWM_W-1:0]          bp_pwm [ROWS];
	pwm_answer_t               due_answers [$];
	pwm_answer_t               want;
	int unsigned               errs;
	int unsigned               row;

	function automatic pwm_answer_t interpolate_pwm(input logic signed [FORCE_W-1:0] q);
		pwm_answer_t a;
		longint      x0, x1, y0, y1, v;
		int unsigned i;
		bit          hit;
		a.pwm = '0;
		a.clamp = CLAMP_NONE;
		hit = 1'b0;
		if (q > bp_force[ROWS-1]) begin
			a.pwm = bp_pwm[ROWS-1];
			a.clamp = CLAMP_HIGH;
		end else if (q < bp_force[0]) begin
			a.pwm = bp_pwm[0];
			a.clamp = CLAMP_LOW;
		end else begin
			for (i = 0; i < ROWS - 1 && !hit; i++) begin
				x0 = bp_force[i];
				x1 = bp_force[i+1];
				if (q >= x0 && q <= x1) begin
					hit = 1'b1;
					y0 = bp_pwm[i];
					y1 = bp_pwm[i+1];
					if (x0 == x1) begin
						v = y0;
					end else begin
						v = y0 + ((y1 - y0) * (q - x0)) / (x1 - x0);
					end
					if (v < 0) begin
						v = 0;
					end else if (v > 65535) begin
						v = 65535;
					end
					a.pwm = v[PWM_W-1:0];
				end
			end
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_answers.delete();
			errs = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_answers.size() == 0) begin
					if (errs < 10) begin
						$display("unexpected result: pwm_code %0d clamped %0d",
							m_tdata[PWM_W-1:0], m_tuser);
					end
					errs++;
				end else begin
					want = due_answers.pop_front();
					if (m_tdata[PWM_W-1:0] !== want.pwm || m_tuser !== want.clamp) begin
						if (errs < 10) begin
							$display("mismatch: pwm_code exp %0d got %0d, clamped exp %0d got %0d",
								want.pwm, m_tdata[PWM_W-1:0], want.clamp, m_tuser);
						end
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == REQ_WRITE) begin
					row = s_tdata[ROW_IDX_LSB +: ROW_IDX_W];
					if (row < ROWS) begin
						bp_force[row] = s_tdata[ROW_FORCE_LSB +: FORCE_W];
						bp_pwm[row] = s_tdata[ROW_PWM_LSB +: PWM_W];
					end
				end else begin
					due_answers.push_back(interpolate_pwm(s_tdata[QUERY_LSB +: FORCE_W]));
				end
			end
			mismatches <= errs;
			outstanding <= due_answers.size();
		end
	end

endmodule

>>> dv/tb_piecewise_linear_interp_lut.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolation table: testbench top
// Loads breakpoint tables of several shapes, sends directed and random
// queries and row writes under varying back-pressure, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_interp_lut;
	import plil_pkg::*;

	localparam int unsigned ROWS        = TABLE_ROWS_DEF;
	localparam int unsigned PHASES      = 3;
	localparam int unsigned SEGMENTS    = 4;
	localparam int unsigned SEG_ITEMS   = 100;
	localparam int unsigned DRAIN       = ROWS + 60;
	localparam int unsigned CYCLE_LIMIT = 2000000;

	typedef enum int unsigned {
		TBL_DIRECTED,
		TBL_ASCEND,
		TBL_REPEAT,
		TBL_FULL_SPAN,
		TBL_NARROW,
		TBL_SCRAMBLED
	} tbl_shape_e;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [0:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [CLAMP_W-1:0]     m_tuser;

	int unsigned s_idle_pct = 26;
	int unsigned r_idle_pct = 70;
	int unsigned cycles = 0;
	int unsigned mismatches;
	int unsigned outstanding;

	logic signed [FORCE_W-1:0] shadow_force [ROWS];

	piecewise_linear_interp_lut #(
		.TABLE_ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	plil_response_checker #(
		.ROWS(ROWS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= r_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic push_item(input logic kind, input logic [ROW_IDX_W-1:0] idx,
			input logic [FORCE_W-1:0] frc, input logic [PWM_W-1:0] pwm,
			input logic [FORCE_W-1:0] q);
		logic [IN_TDATA_W-1:0] word;
		word = '0;
		word[ROW_IDX_LSB +: ROW_IDX_W] = idx;
		word[ROW_FORCE_LSB +: FORCE_W] = frc;
		word[ROW_PWM_LSB +: PWM_W] = pwm;
		word[QUERY_LSB +: FORCE_W] = q;
		while ($urandom_range(99) < s_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= word;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		if (kind == REQ_WRITE && idx < ROWS) begin
			shadow_force[idx] = frc;
		end
	endtask

	task automatic write_row(input logic [ROW_IDX_W-1:0] idx, input logic [FORCE_W-1:0] frc,
			input logic [PWM_W-1:0] pwm);
		push_item(REQ_WRITE, idx, frc, pwm, FORCE_W'($urandom));
	endtask

	task automatic send_query(input logic [FORCE_W-1:0] q);
		push_item(REQ_QUERY, ROW_IDX_W'($urandom), FORCE_W'($urandom), PWM_W'($urandom), q);
	endtask

	task automatic load_table(input tbl_shape_e shape);
		int               f;
		int               span;
		int unsigned      i;
		logic [PWM_W-1:0] y;
		span = 65535 / ROWS;
		if (shape == TBL_NARROW) begin
			f = int'($urandom_range(60000)) - 30000;
		end else begin
			f = int'($urandom_range(8192)) - 32768;
		end
		for (i = 0; i < ROWS; i++) begin
			y = PWM_W'($urandom);
			case (shape)
				TBL_DIRECTED: begin
					f = (i == 1) ? -20000 : -20000 + 1000 * int'(i);
					y = i[0] ? 16'hFFFF : 16'h0000;
				end
				TBL_ASCEND: if (i > 0) f += 1 + int'($urandom_range(span - 1));
				TBL_REPEAT: begin
					if (i > 0 && $urandom_range(2) != 0) begin
						f += 1 + int'($urandom_range(span / 2));
					end
				end
				TBL_FULL_SPAN: begin
					f = -32768 + (65535 * int'(i)) / int'(ROWS - 1);
					y = i[0] ? 16'hFFFF : 16'h0000;
				end
				TBL_NARROW: if (i > 0) f += int'($urandom_range(3, 1));
				default: f = int'($urandom_range(65535)) - 32768;
			endcase
			if (f > 32767) begin
				f = 32767;
			end
			write_row(i[ROW_IDX_W-1:0], f[FORCE_W-1:0], y);
		end
	endtask

	initial begin
		int                   lo, hi, t;
		int unsigned          p, seg, n, i, sel;
		logic [ROW_IDX_W-1:0] idx;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rows 0 and 1 share a force, so a query there meets a zero-width interval.
		load_table(TBL_DIRECTED);
		send_query(16'h8000);
		send_query(16'h7FFF);
		send_query(-16'sd20001);
		send_query(16'sd19001);
		send_query(-16'sd20000);
		send_query(16'sd19000);
		send_query(-16'sd19999);
		send_query(-16'sd17001);
		send_query(-16'sd17000);
		send_query(16'sd0);
		write_row(6'd63, 16'h7FFF, 16'hFFFF);
		write_row(ROWS[ROW_IDX_W-1:0], 16'h8000, 16'h0000);
		send_query(16'h7FFF);
		write_row(ROWS[ROW_IDX_W-1:0] - 1'b1, 16'h7FFF, 16'd12345);
		send_query(16'h7FFF);
		send_query(16'sd30000);
		write_row(6'd0, 16'h8000, 16'hFFFF);
		send_query(16'h8000);
		send_query(-16'sd26000);

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					s_idle_pct = 26;
					r_idle_pct = 70;
				end
				1: begin
					s_idle_pct = 70;
					r_idle_pct = 26;
				end
				default: begin
					s_idle_pct = 0;
					r_idle_pct = 0;
				end
			endcase
			for (seg = 0; seg < SEGMENTS; seg++) begin
				load_table(tbl_shape_e'($urandom_range(TBL_SCRAMBLED, TBL_ASCEND)));
				for (n = 0; n < SEG_ITEMS; n++) begin
					if ($urandom_range(99) < 85) begin
						i = $urandom_range(ROWS - 2);
						lo = shadow_force[i];
						hi = shadow_force[i+1];
						if (lo > hi) begin
							t = lo;
							lo = hi;
							hi = t;
						end
						sel = $urandom_range(99);
						if (sel < 55) begin
							t = lo + int'($urandom_range(hi - lo));
						end else if (sel < 70) begin
							t = shadow_force[$urandom_range(ROWS - 1)];
						end else if (sel < 78) begin
							t = int'(shadow_force[0]) - 1 - int'($urandom_range(3));
						end else if (sel < 86) begin
							t = int'(shadow_force[ROWS-1]) + 1 + int'($urandom_range(3));
						end else if (sel < 90) begin
							t = sel[0] ? 32767 : -32768;
						end else begin
							t = int'($urandom);
						end
						send_query(t[FORCE_W-1:0]);
					end else begin
						idx = ROW_IDX_W'($urandom);
						t = int'($urandom);
						if (idx < ROWS && $urandom_range(3) != 0) begin
							t = int'(shadow_force[idx]) + int'($urandom_range(16)) - 8;
						end
						write_row(idx, t[FORCE_W-1:0], PWM_W'($urandom));
					end
				end
			end
		end
		s_tvalid <= 1'b0;

		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/plil_pkg.sv
hdl/plil_table_mem.sv
hdl/plil_divider.sv
hdl/piecewise_linear_interp_lut.sv
dv/plil_response_checker.sv
dv/tb_piecewise_linear_interp_lut.sv
